FILE: rtl/lrr_pkg.sv
package lrr_pkg;

  // Generator constants
  localparam logic [15:0] LRR_MULT       = 16'd48271;
  localparam logic [30:0] LRR_SEED_RESET = 31'd4660;
  localparam logic [30:0] LRR_SEED_ONE   = 31'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_op;    // capture the two bounds, ordered
    logic step_mul;   // state times multiplier, span of the range
    logic step_fold;  // reduce the product modulo 2^31-1
    logic scale_mul;  // odd fraction times span
    logic load_out;   // fill the output register
  } lrr_cmd_t;

endpackage

FILE: rtl/lehmer_random_range_draw.sv
// Lehmer random range draw.
// Input channel (in_valid_i / in_ready_o) carries two signed bounds; their
// order does not matter. Each transfer advances a 31-bit minimal-standard
// generator (multiplier 48271, modulus 2^31-1) and returns one result on
// the output channel (out_valid_o / out_ready_i): an integer in the
// inclusive range, the low 16 bits of the new state and the state itself.
// Each item runs through the chain multiply, modular fold, scale multiply
// and result add in order, one step per state in one datapath, and a new
// item is not taken until the previous one is in its result step.
// The next item is taken in the same cycle the previous result is loaded.
// Seed: seed_we_i writes seed_value_i into the generator state at once
// (zero loads one); write it only while no draw is in flight.
// Reset: generator state is 4660, no result is pending, input is ready.
// Receiver stall: the result waits in the output register; one more item
// may be accepted and run up to its result step, then input stalls.
module lehmer_random_range_draw import lrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               seed_we_i,
  input  logic        [30:0] seed_value_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] draw_value_o,
  output logic        [15:0] draw_fraction_o,
  output logic        [30:0] generator_state_o
);

  lrr_cmd_t cmd;

  lrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lrr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .seed_we_i         (seed_we_i),
    .seed_value_i      (seed_value_i),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .draw_value_o      (draw_value_o),
    .draw_fraction_o   (draw_fraction_o),
    .generator_state_o (generator_state_o)
  );

endmodule

FILE: rtl/lrr_ctrl.sv
module lrr_ctrl import lrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lrr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_WB) && out_free);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Sequence one draw through the datapath
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load_op = in_xfer;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.step_mul = 1'b1;
        state_d = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.step_fold = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.scale_mul = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = in_valid_i ? S_MUL1 : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_MUL1)
    else $error("accepted item did not start the multiply step");

  a_mul_then_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL1 |=> state_q == S_FOLD)
    else $error("fold step skipped");

  a_fold_then_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FOLD |=> (state_q == S_MUL2 && !in_ready_o))
    else $error("scale step skipped or input taken mid-draw");

endmodule

FILE: rtl/lrr_dp.sv
module lrr_dp import lrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrr_cmd_t           cmd_i,
  input  logic               seed_we_i,
  input  logic        [30:0] seed_value_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic signed [31:0] draw_value_o,
  output logic        [15:0] draw_fraction_o,
  output logic        [30:0] generator_state_o
);

  logic        [30:0] gen_q;
  logic signed [31:0] low_q, high_q;
  logic        [46:0] prod_q;
  logic        [32:0] span_q;
  logic        [48:0] scale_q;
  logic signed [31:0] draw_q;
  logic        [15:0] frac_q;
  logic        [30:0] gen_out_q;

  logic        [46:0] prod_d;
  logic        [32:0] span_d;
  logic        [31:0] fold_sum, fold_sum_p1;
  logic        [30:0] gen_d;
  logic        [48:0] scale_d;
  logic signed [31:0] draw_d;

  assign prod_d = 47'(gen_q) * 47'(LRR_MULT);
  assign span_d = {high_q[31], high_q} - {low_q[31], low_q} + 33'd1;

  // Fold 2^31 into 1: the sum stays below twice the modulus
  assign fold_sum    = {16'd0, prod_q[46:31]} + {1'b0, prod_q[30:0]};
  assign fold_sum_p1 = fold_sum + 32'd1;
  assign gen_d       = fold_sum_p1[31] ? fold_sum_p1[30:0] : fold_sum[30:0];

  // Scale the half-step fraction by the span; offset is the top bits
  assign scale_d = 49'({gen_q[15:0], 1'b1}) * 49'(span_q);
  assign draw_d  = low_q + $signed(scale_q[48:17]);

  // Generator state: reload on seed write, advance on fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= LRR_SEED_RESET;
    end else if (seed_we_i) begin
      gen_q <= (seed_value_i == '0) ? LRR_SEED_ONE : seed_value_i;
    end else if (cmd_i.step_fold) begin
      gen_q <= gen_d;
    end
  end

  // Operand, product and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      if (range_high_i < range_low_i) begin
        low_q  <= range_high_i;
        high_q <= range_low_i;
      end else begin
        low_q  <= range_low_i;
        high_q <= range_high_i;
      end
    end
    if (cmd_i.step_mul) begin
      prod_q <= prod_d;
      span_q <= span_d;
    end
    if (cmd_i.scale_mul) scale_q <= scale_d;
    if (cmd_i.load_out) begin
      draw_q    <= draw_d;
      frac_q    <= gen_q[15:0];
      gen_out_q <= gen_q;
    end
  end

  assign draw_value_o      = draw_q;
  assign draw_fraction_o   = frac_q;
  assign generator_state_o = gen_out_q;

endmodule

FILE: tb/lrr_draw_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the seed port, predicts each draw from its own
// copy of the generator state, and compares every result transfer in order.
module lrr_draw_checker import lrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               seed_we_i,
  input  logic        [30:0] seed_value_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] draw_value_i,
  input  logic        [15:0] draw_fraction_i,
  input  logic        [30:0] generator_state_i,
  output int                 error_count_o,
  output int                 pending_count_o
);

  localparam logic [63:0] LEHMER_MODULUS = 64'd2147483647;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [15:0] fraction;
    logic        [30:0] state;
  } draw_result_t;

  draw_result_t expected_draws[$];
  logic [30:0]  gen_state;

  // One Lehmer step, taken as a plain product mod 2^31-1
  function automatic logic [30:0] lehmer_advance(input logic [30:0] s);
    logic [63:0] prod;
    prod = {33'd0, s} * {48'd0, LRR_MULT};
    return 31'(prod % LEHMER_MODULUS);
  endfunction

  // Order the bounds and scale the odd fraction by the 33-bit span
  function automatic logic signed [31:0] scale_draw(input logic signed [31:0] lo_in,
                                                    input logic signed [31:0] hi_in,
                                                    input logic [15:0] frac);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] tmp;
    logic        [63:0] span;
    logic        [63:0] offset;
    lo = {{32{lo_in[31]}}, lo_in};
    hi = {{32{hi_in[31]}}, hi_in};
    if (hi < lo) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    span   = 64'(hi - lo) + 64'd1;
    offset = ({47'd0, frac, 1'b1} * span) >> 17;
    return 32'(lo + offset);
  endfunction

  task automatic report_field(input string field, input longint expv, input longint actv);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
    error_count_o = error_count_o + 1;
  endtask

  initial begin
    error_count_o   = 0;
    pending_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    draw_result_t want;
    draw_result_t got;
    if (!rst_ni) begin
      gen_state = LRR_SEED_RESET;
      expected_draws.delete();
    end else begin
      // Compare a result transfer before taking a new request
      if (out_valid_i && out_ready_i) begin
        got = '{draw_value_i, draw_fraction_i, generator_state_i};
        if (expected_draws.size() == 0) begin
          $display("%0t: unexpected result, got value %0d fraction %0d state %0d",
                   $time, got.value, got.fraction, got.state);
          error_count_o = error_count_o + 1;
        end else begin
          want = expected_draws.pop_front();
          if (got.value !== want.value)
            report_field("draw_value", want.value, got.value);
          if (got.fraction !== want.fraction)
            report_field("draw_fraction", want.fraction, got.fraction);
          if (got.state !== want.state)
            report_field("generator_state", want.state, got.state);
        end
      end
      // Reload the generator on a seed write; zero loads one
      if (seed_we_i)
        gen_state = (seed_value_i == '0) ? LRR_SEED_ONE : seed_value_i;
      // Advance and predict on a request transfer
      if (in_valid_i && in_ready_i) begin
        gen_state   = lehmer_advance(gen_state);
        want.fraction = gen_state[15:0];
        want.state  = gen_state;
        want.value  = scale_draw(range_low_i, range_high_i, gen_state[15:0]);
        expected_draws.push_back(want);
      end
    end
    pending_count_o = expected_draws.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lrr_pkg::*;

  localparam int                 IDLE_LIMIT = 2000;
  localparam int                 PHASES     = 10;
  localparam int                 PHASE_ITEMS = 108;
  localparam logic signed [31:0] RANGE_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] RANGE_MAX  = 32'sh7FFF_FFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               seed_we_i = 1'b0;
  logic        [30:0] seed_value_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] range_low_i = '0;
  logic signed [31:0] range_high_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] draw_value_o;
  logic        [15:0] draw_fraction_o;
  logic        [30:0] generator_state_o;

  int error_count;
  int pending_draws;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  lehmer_random_range_draw uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .seed_we_i         (seed_we_i),
    .seed_value_i      (seed_value_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .draw_value_o      (draw_value_o),
    .draw_fraction_o   (draw_fraction_o),
    .generator_state_o (generator_state_o)
  );

  lrr_draw_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .seed_we_i         (seed_we_i),
    .seed_value_i      (seed_value_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .draw_value_i      (draw_value_o),
    .draw_fraction_i   (draw_fraction_o),
    .generator_state_i (generator_state_o),
    .error_count_o     (error_count),
    .pending_count_o   (pending_draws)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: alternate ready runs with stalls unless in a calm stretch
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      out_ready_i <= 1'b1;
    end else if (out_ready_i) begin
      out_ready_i <= 1'b0;
      rx_hold     <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
      rx_hold     <= $urandom_range(0, 7);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || seed_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_range(input logic signed [31:0] lo, input logic signed [31:0] hi);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    range_low_i  <= lo;
    range_high_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain all draws, then write the seed register; the extra edge lets the
  // checker count a transfer taken at the edge just passed
  task automatic write_seed(input logic [30:0] seed);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_draws != 0) @(posedge clk_i);
    seed_we_i    <= 1'b1;
    seed_value_i <= seed;
    @(posedge clk_i);
    seed_we_i    <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_corner();
    case ($urandom_range(0, 6))
      0: return RANGE_MIN;
      1: return RANGE_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return RANGE_MIN + 32'sd1;
      default: return RANGE_MAX - 32'sd1;
    endcase
  endfunction

  // Random request: wide, narrow, near zero, corners, equal, reversed
  task automatic send_random_range();
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    int                 pick;
    pick = $urandom_range(0, 99);
    lo   = $urandom;
    hi   = $urandom;
    if (pick < 30) begin
      // keep both fully random
    end else if (pick < 50) begin
      hi = lo + $urandom_range(0, 15);
    end else if (pick < 65) begin
      lo = $urandom_range(0, 2000) - 1000;
      hi = $urandom_range(0, 2000) - 1000;
    end else if (pick < 80) begin
      lo = pick_corner();
      hi = pick_corner();
    end else if (pick < 90) begin
      hi = lo;
    end else begin
      hi = (lo < hi) ? lo : hi;
      lo = hi + $urandom_range(1, 1000000);
    end
    send_range(lo, hi);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset seed, bound extremes, equal and reversed bounds
    send_range(32'sd0, 32'sd0);
    send_range(RANGE_MIN, RANGE_MAX);
    send_range(RANGE_MAX, RANGE_MIN);
    send_range(RANGE_MAX, RANGE_MAX);
    send_range(RANGE_MIN, RANGE_MIN);
    send_range(-32'sd1, 32'sd0);
    send_range(32'sd0, -32'sd1);
    send_range(32'sd5, -32'sd5);
    send_range(-32'sd100, 32'sd100);
    send_range(RANGE_MIN, RANGE_MIN + 32'sd1);
    send_range(RANGE_MAX - 32'sd1, RANGE_MAX);
    send_range(32'sd0, 32'sd65535);
    send_range(32'sh5555_5555, 32'shAAAA_AAAA);
    send_range(32'shAAAA_AAAA, 32'sh5555_5555);

    // Zero seed loads one
    write_seed(31'd0);
    send_range(32'sd0, 32'sd9);
    send_range(RANGE_MIN, RANGE_MAX);

    // All-ones seed equals the modulus: the generator sticks at zero
    write_seed(31'h7FFF_FFFF);
    send_range(RANGE_MIN, RANGE_MAX);
    send_range(32'sd0, 32'sd0);
    send_range(RANGE_MAX, -32'sd7);

    write_seed(31'h7FFF_FFFE);
    send_range(RANGE_MIN, RANGE_MAX);
    send_range(32'sd1, 32'sd6);

    // Random phases, each under a fresh seed and its own idling mix
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_seed(31'd1);
        1:       write_seed(LRR_SEED_RESET);
        2:       write_seed(31'h5555_5555);
        3:       write_seed(31'h2AAA_AAAA);
        default: write_seed(31'($urandom));
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_range();
    end

    // Drain and let the block settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_draws != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
